// File: rtl/ata_seq_pkg.sv
// ----------------------------------------------------------------------------
// ATA PIO LBA48 read sequencer package
// Shared item types, job descriptor, action codes and task-file constants.
// ----------------------------------------------------------------------------
package ata_seq_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_STATUS = 2'd1;
  localparam logic [1:0] CMD_DATA   = 2'd2;

  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_RSTAT = 3'd1;
  localparam logic [2:0] ACT_RDATA = 3'd2;
  localparam logic [2:0] ACT_STORE = 3'd3;
  localparam logic [2:0] ACT_DONE  = 3'd4;

  localparam logic [1:0] CODE_OK      = 2'd0;
  localparam logic [1:0] CODE_TIMEOUT = 2'd1;
  localparam logic [1:0] CODE_ERROR   = 2'd2;

  localparam logic [2:0] OFF_DATA   = 3'd0;
  localparam logic [2:0] OFF_COUNT  = 3'd2;
  localparam logic [2:0] OFF_LBA_LO = 3'd3;
  localparam logic [2:0] OFF_LBA_MI = 3'd4;
  localparam logic [2:0] OFF_LBA_HI = 3'd5;
  localparam logic [2:0] OFF_DRIVE  = 3'd6;
  localparam logic [2:0] OFF_CMD    = 3'd7;

  localparam logic [7:0] ST_BSY = 8'h80;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_DF  = 8'h20;
  localparam logic [7:0] ST_ERR = 8'h01;

  localparam logic [7:0]  CMD_READ_EXT     = 8'h24;
  localparam logic [31:0] POLL_LIMIT_RESET = 32'd1000000;
  localparam logic [7:0]  WORD_LAST        = 8'hff;

  localparam logic [3:0] STEPS_START = 4'd11;
  localparam logic [3:0] STEPS_STORE = 4'd2;
  localparam logic [3:0] STEPS_ONE   = 4'd1;

  typedef enum logic [2:0] {
    JOB_START,
    JOB_RSTAT,
    JOB_RDATA,
    JOB_DONE,
    JOB_STORE
  } job_kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  drive_select;
    logic [15:0] sector_count;
    logic [47:0] lba;
    logic [7:0]  status_byte;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  reg_offset;
    logic [7:0]  write_value;
    logic [15:0] word;
    logic [23:0] word_index;
    logic [1:0]  status_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    job_kind_e   kind;
    job_kind_e   follow;
    logic [1:0]  code;
    logic [7:0]  drive;
    logic [15:0] count;
    logic [47:0] lba;
    logic [15:0] word;
    logic [23:0] word_index;
  } job_t;

endpackage

// File: rtl/ata_seq_front.sv
// ----------------------------------------------------------------------------
// ATA sequencer front end
// Accepts start requests and bus replies, tracks the read's progress and
// issues one job descriptor per item that produces results.
// ----------------------------------------------------------------------------
module ata_seq_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  ata_seq_pkg::in_item_t in_data_i,
  output logic                  in_stall_o,
  input  logic                  cfg_valid_i,
  input  logic [31:0]           cfg_data_i,
  output logic                  cfg_ready_o,
  output logic                  job_valid_o,
  output ata_seq_pkg::job_t     job_o,
  input  logic                  job_full_i
);
  import ata_seq_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POLL,
    PH_DATA
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] total_q, total_d;
  logic [15:0] sector_q, sector_d;
  logic [7:0]  word_q, word_d;
  logic [31:0] poll_q, poll_d;
  logic [31:0] limit_q;
  logic [31:0] limit;
  logic [31:0] poll_inc;
  logic [15:0] sector_inc;
  logic        accept;
  job_t        job;
  logic        job_valid;

  assign in_stall_o  = job_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !job_full_i;
  assign limit       = (limit_q == '0) ? 32'd1 : limit_q;
  assign poll_inc    = poll_q + 32'd1;
  assign sector_inc  = sector_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    total_d   = total_q;
    sector_d  = sector_q;
    word_d    = word_q;
    poll_d    = poll_q;
    job_valid = 1'b0;
    job       = '0;
    job.kind  = JOB_RSTAT;
    job.follow = JOB_RSTAT;
    unique case (in_data_i.cmd)
      CMD_START: begin
        job_valid = 1'b1;
        job.kind  = JOB_START;
        job.drive = in_data_i.drive_select;
        job.count = in_data_i.sector_count;
        job.lba   = in_data_i.lba;
        total_d   = in_data_i.sector_count;
        sector_d  = '0;
        word_d    = '0;
        poll_d    = '0;
        phase_d   = (in_data_i.sector_count == '0) ? PH_IDLE : PH_POLL;
      end
      CMD_STATUS: begin
        if (phase_q == PH_POLL) begin
          job_valid = 1'b1;
          poll_d    = poll_inc;
          if ((in_data_i.status_byte & (ST_ERR | ST_DF)) != '0) begin
            job.kind  = JOB_DONE;
            job.code  = CODE_ERROR;
            phase_d   = PH_IDLE;
          end else if ((in_data_i.status_byte & (ST_BSY | ST_DRQ)) == ST_DRQ) begin
            job.kind  = JOB_RDATA;
            phase_d   = PH_DATA;
            word_d    = '0;
          end else if (poll_inc >= limit) begin
            job.kind  = JOB_DONE;
            job.code  = CODE_TIMEOUT;
            phase_d   = PH_IDLE;
          end else begin
            job.kind  = JOB_RSTAT;
          end
        end
      end
      CMD_DATA: begin
        if (phase_q == PH_DATA) begin
          job_valid      = 1'b1;
          job.kind       = JOB_STORE;
          job.word       = in_data_i.data_word;
          job.word_index = {sector_q, word_q};
          if (word_q == WORD_LAST) begin
            word_d   = '0;
            sector_d = sector_inc;
            if (sector_inc >= total_q) begin
              job.follow = JOB_DONE;
              job.code   = CODE_OK;
              phase_d    = PH_IDLE;
            end else begin
              job.follow = JOB_RSTAT;
              phase_d    = PH_POLL;
              poll_d     = '0;
            end
          end else begin
            word_d     = word_q + 8'd1;
            job.follow = JOB_RDATA;
          end
        end
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

  assign job_valid_o = accept && job_valid;
  assign job_o       = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      total_q  <= '0;
      sector_q <= '0;
      word_q   <= '0;
      poll_q   <= '0;
      limit_q  <= POLL_LIMIT_RESET;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        total_q  <= total_d;
        sector_q <= sector_d;
        word_q   <= word_d;
        poll_q   <= poll_d;
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule

// File: rtl/ata_seq_queue.sv
// ----------------------------------------------------------------------------
// ATA sequencer job queue
// A short first-in first-out queue of job descriptors between the front end
// and the result generator.
// ----------------------------------------------------------------------------
module ata_seq_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ata_seq_pkg::job_t push_data_i,
  output logic              full_o,
  output logic              valid_o,
  output ata_seq_pkg::job_t head_o,
  input  logic              pop_i
);
  import ata_seq_pkg::*;

  job_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign push    = push_i && !full_o;
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/ata_seq_back.sv
// ----------------------------------------------------------------------------
// ATA sequencer result generator
// Expands each job descriptor into its result items, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ata_seq_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  ata_seq_pkg::job_t      job_i,
  output logic                   job_pop_o,
  output logic                   out_valid_o,
  output ata_seq_pkg::out_item_t out_data_o,
  input  logic                   out_stall_i
);
  import ata_seq_pkg::*;

  logic [3:0] step_q;
  logic [3:0] steps;
  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  res;
  logic       advance;
  logic       step_end;

  function automatic out_item_t single_res(job_kind_e kind, logic [1:0] code);
    out_item_t r;
    r = '0;
    unique case (kind)
      JOB_RSTAT: begin
        r.action     = ACT_RSTAT;
        r.reg_offset = OFF_CMD;
      end
      JOB_RDATA: begin
        r.action     = ACT_RDATA;
        r.reg_offset = OFF_DATA;
      end
      JOB_DONE: begin
        r.action      = ACT_DONE;
        r.status_code = code;
        r.last        = 1'b1;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    unique case (job_i.kind)
      JOB_START: steps = STEPS_START;
      JOB_STORE: steps = STEPS_STORE;
      default:   steps = STEPS_ONE;
    endcase
  end

  always_comb begin
    res = '0;
    unique case (job_i.kind)
      JOB_START: begin
        res.action = ACT_WRITE;
        unique case (step_q)
          4'd0: begin res.reg_offset = OFF_DRIVE;  res.write_value = job_i.drive;        end
          4'd1: begin res.reg_offset = OFF_COUNT;  res.write_value = job_i.count[15:8];  end
          4'd2: begin res.reg_offset = OFF_LBA_LO; res.write_value = job_i.lba[31:24];   end
          4'd3: begin res.reg_offset = OFF_LBA_MI; res.write_value = job_i.lba[39:32];   end
          4'd4: begin res.reg_offset = OFF_LBA_HI; res.write_value = job_i.lba[47:40];   end
          4'd5: begin res.reg_offset = OFF_COUNT;  res.write_value = job_i.count[7:0];   end
          4'd6: begin res.reg_offset = OFF_LBA_LO; res.write_value = job_i.lba[7:0];     end
          4'd7: begin res.reg_offset = OFF_LBA_MI; res.write_value = job_i.lba[15:8];    end
          4'd8: begin res.reg_offset = OFF_LBA_HI; res.write_value = job_i.lba[23:16];   end
          4'd9: begin res.reg_offset = OFF_CMD;    res.write_value = CMD_READ_EXT;       end
          default: begin
            res = (job_i.count == '0) ? single_res(JOB_DONE, CODE_OK)
                                      : single_res(JOB_RSTAT, CODE_OK);
          end
        endcase
      end
      JOB_STORE: begin
        if (step_q == '0) begin
          res.action     = ACT_STORE;
          res.word       = job_i.word;
          res.word_index = job_i.word_index;
        end else begin
          res = single_res(job_i.follow, job_i.code);
        end
      end
      default: begin
        res = single_res(job_i.kind, job_i.code);
      end
    endcase
  end

  assign advance     = job_valid_i && (!out_valid_q || !out_stall_i);
  assign step_end    = (step_q == steps - 4'd1);
  assign job_pop_o   = advance && step_end;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        step_q      <= step_end ? 4'd0 : step_q + 4'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ata_pio_lba48_read_sequencer_unit.sv
// ----------------------------------------------------------------------------
// ATA PIO LBA48 read sequencer
// Host-side sequencer that turns read requests and bus replies into
// task-file writes, status and data reads, stored words and completion.
// ----------------------------------------------------------------------------
// An input item is taken whenever the four-entry job queue has room, and
// results leave through a registered output stage at one per cycle while
// out_stall_i is low. The output stage therefore sets the sustained rate: a
// start request yields 11 result items, a data reply 2 and a status reply 1,
// while replies that do not fit the current phase produce no transfer.
module ata_pio_lba48_read_sequencer_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  ata_seq_pkg::in_item_t  in_data_i,
  output logic                   in_stall_o,
  input  logic                   cfg_valid_i,
  input  logic [31:0]            cfg_data_i,
  output logic                   cfg_ready_o,
  output logic                   out_valid_o,
  output ata_seq_pkg::out_item_t out_data_o,
  input  logic                   out_stall_i
);
  import ata_seq_pkg::*;

  logic job_push;
  job_t job_in;
  logic job_full;
  logic job_valid;
  job_t job_head;
  logic job_pop;

  ata_seq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .job_valid_o (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  ata_seq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (job_full),
    .valid_o     (job_valid),
    .head_o      (job_head),
    .pop_i       (job_pop)
  );

  ata_seq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
